[rtl/core/ablm_pkg.sv]
// Shared types and constants for the block level meter.
// No dependencies; ablm_div and audio_block_level_meter_core use this package.
package ablm_pkg;

  localparam logic [23:0] RECORD_LENGTH_RESET = 24'd480000;
  localparam logic [21:0] LOG_K               = 22'd3945660;
  localparam logic signed [10:0] SILENT_TENTHS = -11'sd960;
  localparam logic [11:0] BARS_RECIP          = 12'd2185;  // 2^16/30, rounded up
  localparam logic [4:0]  BARS_MAX            = 5'd20;
  localparam logic [6:0]  PROGRESS_FULL       = 7'd100;

  // serial divider widths
  localparam int DIV_NW = 56;
  localparam int DIV_DW = 24;
  localparam int DIV_CW = 6;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQR,
    ST_START,
    ST_MS_GO,
    ST_MS_WAIT,
    ST_SQRT,
    ST_LOG_START,
    ST_NORM,
    ST_LOGSQ,
    ST_LOGMUL,
    ST_LOGFIN,
    ST_BARS,
    ST_PR_GO,
    ST_PR_WAIT,
    ST_AV_GO,
    ST_AV_WAIT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
  } div_ctl_t;

endpackage

[rtl/core/ablm_if.sv]
// Handshake channels for the level meter: sample words in, result words out.
// Depends on nothing.
interface ablm_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               block_end;
  modport source (output valid, sample, block_end, input ready);
  modport sink   (input valid, sample, block_end, output ready);
endinterface

interface ablm_out_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic               last;
  logic [15:0]        rms;
  logic signed [10:0] level_tenth_db;
  logic [4:0]         bars;
  logic [6:0]         progress_percent;
  logic signed [15:0] max_amplitude;
  logic signed [15:0] min_amplitude;
  logic signed [23:0] average_q8;
  logic [23:0]        samples_recorded;
  modport source (output valid, kind, last, rms, level_tenth_db, bars, progress_percent,
                  max_amplitude, min_amplitude, average_q8, samples_recorded,
                  input ready);
  modport sink   (input valid, kind, last, rms, level_tenth_db, bars, progress_percent,
                  max_amplitude, min_amplitude, average_q8, samples_recorded,
                  output ready);
endinterface

[rtl/core/ablm_div.sv]
// Restoring divider, one quotient bit per cycle.
// Depends on ablm_pkg for its widths.
module ablm_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [ablm_pkg::DIV_NW-1:0]  dividend,
  input  logic [ablm_pkg::DIV_DW-1:0]  divisor,
  output logic                         busy,
  output logic [ablm_pkg::DIV_NW-1:0]  quotient
);
  localparam int NW = ablm_pkg::DIV_NW;
  localparam int DW = ablm_pkg::DIV_DW;
  localparam int CW = ablm_pkg::DIV_CW;

  logic [NW-1:0] q_r;
  logic [DW-1:0] rem_r, d_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic [DW:0]   rem_sh;
  logic [DW+1:0] diff;
  logic          ge;

  assign rem_sh = {rem_r, q_r[NW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, d_r};
  assign ge     = ~diff[DW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
      q_r    <= dividend;
      d_r    <= divisor;
      rem_r  <= '0;
    end else if (busy_r) begin
      q_r   <= {q_r[NW-2:0], ge};
      rem_r <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CW'(NW - 1)) busy_r <= 1'b0;
    end
  end

  assign busy     = busy_r;
  assign quotient = q_r;
endmodule

[rtl/core/audio_block_level_meter_core.sv]
// Block RMS level meter with whole-recording statistics.
// Depends on ablm_pkg, the channel interfaces in ablm_if and the divider ablm_div.
//
// Usage:
//   in_ch carries one sample word with its block_end flag; out_ch carries result
//   words. cfg_wr_en/cfg_wr_data write record_length; the user must do so only
//   while the block is idle, which the block leaves unenforced. A sample that
//   does not end a block takes a serial 16-step squaring. A block end adds the
//   report: a mean-square divide, 16 square-root steps, for a non-zero RMS up to
//   15 normalising shifts and 16 log squaring steps, a few fixed steps and, while
//   the recording is incomplete, a progress divide. The summary word repeats the
//   divide, root and log, skips the progress divide and adds an average divide;
//   an empty recording skips all of them. The divides share one divider.
//   One item is worked on at a time; in_ch.ready is high only when no work is
//   in hand. A finished word sits in the output register, so the next sample is
//   taken while it waits; a stalled receiver holds back the next word and with it
//   sample intake. Reset (synchronous, active low) clears all statistics,
//   restores record_length to 480000 and empties the output register. After the
//   summary word every sample is taken and dropped until reset.
module audio_block_level_meter_core #(
  parameter int MAX_BLOCK = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  ablm_in_if.sink     in_ch,
  ablm_out_if.source  out_ch,
  input  logic        cfg_wr_en,
  input  logic [23:0] cfg_wr_data
);
  localparam int BCW = $clog2(MAX_BLOCK + 1);
  localparam int BSW = 31 + $clog2(MAX_BLOCK);
  localparam int NW  = ablm_pkg::DIV_NW;

  ablm_pkg::state_t state_r, state_nxt;
  ablm_pkg::div_ctl_t div_ctl;

  logic [23:0]        len_r;
  logic [BSW-1:0]     blk_sum_r;
  logic [BCW-1:0]     blk_cnt_r;
  logic [23:0]        rec_cnt_r;
  logic signed [15:0] rec_max_r, rec_min_r;
  logic signed [39:0] rec_sum_r;
  logic [54:0]        rec_sq_r;
  logic               finished_r;

  logic               ends_r, recupd_r, kind_r;
  logic [3:0]         step_r;
  logic [31:0]        mc_r, acc_r;
  logic [15:0]        mb_r;
  logic [31:0]        sv_r;
  logic [17:0]        srem_r;
  logic [15:0]        root_r, rms_r;
  logic [30:0]        m_r;
  logic [3:0]         e_r;
  logic [15:0]        frac_r;
  logic [41:0]        prod_r;
  logic signed [10:0] lv_r;
  logic [4:0]         bars_r;
  logic [6:0]         prog_r;
  logic signed [23:0] avg_r;

  logic               out_valid_r;
  logic               o_kind_r, o_last_r;
  logic [15:0]        o_rms_r;
  logic signed [10:0] o_lv_r;
  logic [4:0]         o_bars_r;
  logic [6:0]         o_prog_r;
  logic signed [15:0] o_max_r, o_min_r;
  logic signed [23:0] o_avg_r;
  logic [23:0]        o_cnt_r;

  logic               in_ready, out_load, accept;
  logic [NW-1:0]      div_a, div_q;
  logic [23:0]        div_b;

  // derived values
  logic               prog_full, summary_due, rec_empty;
  logic [BCW-1:0]     blk_cnt_inc;
  logic [15:0]        s_abs;
  logic [31:0]        sq_nxt;
  logic [19:0]        srem_sh;
  logic [17:0]        trial;
  logic               sq_ge;
  logic [15:0]        root_nxt;
  logic [61:0]        msq;
  logic [19:0]        mag;
  logic [42:0]        rnd;
  logic signed [11:0] bar_in;
  logic [21:0]        bar_prod;
  logic [5:0]         bar_q;
  logic               sum_neg;
  logic [39:0]        sum_mag;
  logic [30:0]        cnt_x100;

  assign prog_full   = (len_r == 24'd0) || (rec_cnt_r >= len_r);
  assign summary_due = rec_cnt_r >= len_r;
  assign rec_empty   = rec_cnt_r == 24'd0;
  assign blk_cnt_inc = blk_cnt_r + 1'b1;
  assign s_abs       = in_ch.sample[15] ? 16'(-in_ch.sample) : 16'(in_ch.sample);
  assign sq_nxt      = acc_r + (mb_r[0] ? mc_r : 32'd0);
  assign srem_sh     = {srem_r, sv_r[31:30]};
  assign trial       = {root_r, 2'b01};
  assign sq_ge       = srem_sh >= {2'b00, trial};
  assign root_nxt    = {root_r[14:0], sq_ge};
  assign msq         = {31'd0, m_r} * {31'd0, m_r};
  assign mag         = {4'(4'd15 - e_r), 16'd0} - {4'd0, frac_r};
  assign rnd         = {1'b0, prod_r} + 43'(64'h8000_0000);
  assign bar_in      = 12'(lv_r) + 12'sd600;
  assign bar_prod    = bar_in[9:0] * ablm_pkg::BARS_RECIP;
  assign bar_q       = bar_prod[21:16];
  assign sum_neg     = rec_sum_r[39];
  assign sum_mag     = sum_neg ? 40'(-rec_sum_r) : 40'(rec_sum_r);
  assign cnt_x100    = {1'b0, rec_cnt_r, 6'd0} + {2'b0, rec_cnt_r, 5'd0}
                     + {5'b0, rec_cnt_r, 2'd0};

  // control outputs
  always_comb begin
    in_ready      = (state_r == ablm_pkg::ST_IDLE);
    out_load      = (state_r == ablm_pkg::ST_EMIT) && (!out_valid_r || out_ch.ready);
    div_ctl.start = (state_r == ablm_pkg::ST_MS_GO) || (state_r == ablm_pkg::ST_PR_GO)
                 || (state_r == ablm_pkg::ST_AV_GO);
  end

  assign accept = in_ch.valid && in_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ablm_pkg::ST_IDLE:      if (accept && !finished_r) state_nxt = ablm_pkg::ST_SQR;
      ablm_pkg::ST_SQR:       if (step_r == 4'd15)
                                state_nxt = ends_r ? ablm_pkg::ST_START : ablm_pkg::ST_IDLE;
      ablm_pkg::ST_START:     state_nxt = (kind_r && rec_empty) ? ablm_pkg::ST_LOG_START
                                                                : ablm_pkg::ST_MS_GO;
      ablm_pkg::ST_MS_GO:     state_nxt = ablm_pkg::ST_MS_WAIT;
      ablm_pkg::ST_MS_WAIT:   if (!div_ctl.busy) state_nxt = ablm_pkg::ST_SQRT;
      ablm_pkg::ST_SQRT:      if (step_r == 4'd15) state_nxt = ablm_pkg::ST_LOG_START;
      ablm_pkg::ST_LOG_START: state_nxt = (rms_r == 16'd0) ? ablm_pkg::ST_BARS
                                                           : ablm_pkg::ST_NORM;
      ablm_pkg::ST_NORM:      if (m_r[30]) state_nxt = ablm_pkg::ST_LOGSQ;
      ablm_pkg::ST_LOGSQ:     if (step_r == 4'd15) state_nxt = ablm_pkg::ST_LOGMUL;
      ablm_pkg::ST_LOGMUL:    state_nxt = ablm_pkg::ST_LOGFIN;
      ablm_pkg::ST_LOGFIN:    state_nxt = ablm_pkg::ST_BARS;
      ablm_pkg::ST_BARS: begin
        if (!prog_full) state_nxt = ablm_pkg::ST_PR_GO;
        else state_nxt = (kind_r && !rec_empty) ? ablm_pkg::ST_AV_GO : ablm_pkg::ST_EMIT;
      end
      ablm_pkg::ST_PR_GO:     state_nxt = ablm_pkg::ST_PR_WAIT;
      ablm_pkg::ST_PR_WAIT:   if (!div_ctl.busy)
                                state_nxt = (kind_r && !rec_empty) ? ablm_pkg::ST_AV_GO
                                                                   : ablm_pkg::ST_EMIT;
      ablm_pkg::ST_AV_GO:     state_nxt = ablm_pkg::ST_AV_WAIT;
      ablm_pkg::ST_AV_WAIT:   if (!div_ctl.busy) state_nxt = ablm_pkg::ST_EMIT;
      ablm_pkg::ST_EMIT:      if (out_load)
                                state_nxt = (!kind_r && summary_due) ? ablm_pkg::ST_START
                                                                     : ablm_pkg::ST_IDLE;
      default:                state_nxt = ablm_pkg::ST_IDLE;
    endcase
  end

  // divider operands
  always_comb begin
    div_a = NW'({cnt_x100});
    div_b = len_r;
    case (state_r)
      ablm_pkg::ST_MS_GO: begin
        div_a = kind_r ? NW'(rec_sq_r) : NW'(blk_sum_r);
        div_b = kind_r ? rec_cnt_r : 24'(blk_cnt_r);
      end
      ablm_pkg::ST_AV_GO: begin
        div_a = NW'({sum_mag, 8'd0});
        div_b = rec_cnt_r;
      end
      default: ;
    endcase
  end

  ablm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_ctl.start),
    .dividend (div_a),
    .divisor  (div_b),
    .busy     (div_ctl.busy),
    .quotient (div_q)
  );

  // control and statistics registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ablm_pkg::ST_IDLE;
      len_r       <= ablm_pkg::RECORD_LENGTH_RESET;
      blk_sum_r   <= '0;
      blk_cnt_r   <= '0;
      rec_cnt_r   <= '0;
      rec_max_r   <= -16'sd32768;
      rec_min_r   <= 16'sd32767;
      rec_sum_r   <= '0;
      rec_sq_r    <= '0;
      finished_r  <= 1'b0;
      out_valid_r <= 1'b0;
      step_r      <= '0;
      kind_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) len_r <= cfg_wr_data;

      if (out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;

      if ((state_r == ablm_pkg::ST_SQR) || (state_r == ablm_pkg::ST_SQRT)
          || (state_r == ablm_pkg::ST_LOGSQ))
        step_r <= step_r + 1'b1;
      else
        step_r <= '0;

      if (accept && !finished_r) begin
        kind_r    <= 1'b0;
        blk_cnt_r <= blk_cnt_inc;
        if (rec_cnt_r < len_r) begin
          rec_cnt_r <= rec_cnt_r + 1'b1;
          if (in_ch.sample > rec_max_r) rec_max_r <= in_ch.sample;
          if (in_ch.sample < rec_min_r) rec_min_r <= in_ch.sample;
          rec_sum_r <= rec_sum_r + 40'(in_ch.sample);
        end
      end

      if (state_r == ablm_pkg::ST_SQR && step_r == 4'd15) begin
        blk_sum_r <= blk_sum_r + BSW'(sq_nxt);
        if (recupd_r) rec_sq_r <= rec_sq_r + 55'(sq_nxt);
      end

      if (out_load) begin
        if (!kind_r) begin
          blk_sum_r <= '0;
          blk_cnt_r <= '0;
          if (summary_due) kind_r <= 1'b1;
        end else begin
          finished_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ablm_pkg::ST_IDLE: begin
        ends_r   <= in_ch.block_end || (blk_cnt_inc >= BCW'(MAX_BLOCK));
        recupd_r <= rec_cnt_r < len_r;
        mc_r     <= {16'd0, s_abs};
        mb_r     <= s_abs;
        acc_r    <= '0;
      end
      ablm_pkg::ST_SQR: begin
        acc_r <= sq_nxt;
        mc_r  <= {mc_r[30:0], 1'b0};
        mb_r  <= {1'b0, mb_r[15:1]};
      end
      ablm_pkg::ST_START: begin
        rms_r <= '0;
        avg_r <= '0;
      end
      ablm_pkg::ST_MS_WAIT: begin
        sv_r   <= div_q[31:0];
        srem_r <= '0;
        root_r <= '0;
      end
      ablm_pkg::ST_SQRT: begin
        srem_r <= sq_ge ? 18'(srem_sh - {2'b00, trial}) : srem_sh[17:0];
        root_r <= root_nxt;
        sv_r   <= {sv_r[29:0], 2'b00};
        if (step_r == 4'd15) rms_r <= root_nxt;
      end
      ablm_pkg::ST_LOG_START: begin
        lv_r   <= ablm_pkg::SILENT_TENTHS;
        m_r    <= {rms_r, 15'd0};
        e_r    <= 4'd15;
        frac_r <= '0;
      end
      ablm_pkg::ST_NORM: begin
        if (!m_r[30]) begin
          m_r <= {m_r[29:0], 1'b0};
          e_r <= e_r - 1'b1;
        end
      end
      ablm_pkg::ST_LOGSQ: begin
        // m stays in [2^30, 2^31): one fraction bit per squaring
        m_r    <= msq[61] ? msq[61:31] : msq[60:30];
        frac_r <= {frac_r[14:0], msq[61]};
      end
      ablm_pkg::ST_LOGMUL: prod_r <= mag * ablm_pkg::LOG_K;
      ablm_pkg::ST_LOGFIN: lv_r <= 11'sd0 - $signed({1'b0, rnd[41:32]});
      ablm_pkg::ST_BARS: begin
        if (bar_in <= 12'sd0) bars_r <= '0;
        else if (bar_q > 6'(ablm_pkg::BARS_MAX)) bars_r <= ablm_pkg::BARS_MAX;
        else bars_r <= bar_q[4:0];
        prog_r <= ablm_pkg::PROGRESS_FULL;
      end
      ablm_pkg::ST_PR_WAIT: prog_r <= div_q[6:0];
      ablm_pkg::ST_AV_WAIT: avg_r <= sum_neg ? 24'(-div_q[23:0]) : div_q[23:0];
      ablm_pkg::ST_EMIT: begin
        if (out_load) begin
          o_kind_r <= kind_r;
          o_last_r <= kind_r || !summary_due;
          o_rms_r  <= rms_r;
          o_lv_r   <= lv_r;
          o_bars_r <= bars_r;
          o_prog_r <= prog_r;
          o_max_r  <= kind_r ? rec_max_r : 16'sd0;
          o_min_r  <= kind_r ? rec_min_r : 16'sd0;
          o_avg_r  <= kind_r ? avg_r : 24'sd0;
          o_cnt_r  <= rec_cnt_r;
        end
      end
      default: ;
    endcase
  end

  assign in_ch.ready             = in_ready;
  assign out_ch.valid            = out_valid_r;
  assign out_ch.kind             = o_kind_r;
  assign out_ch.last             = o_last_r;
  assign out_ch.rms              = o_rms_r;
  assign out_ch.level_tenth_db   = o_lv_r;
  assign out_ch.bars             = o_bars_r;
  assign out_ch.progress_percent = o_prog_r;
  assign out_ch.max_amplitude    = o_max_r;
  assign out_ch.min_amplitude    = o_min_r;
  assign out_ch.average_q8       = o_avg_r;
  assign out_ch.samples_recorded = o_cnt_r;
endmodule

[rtl/core/ablm_chk.sv]
// Port-level checks for the level meter, bound to the top level.
// Depends on audio_block_level_meter_core and its channel interfaces.
module ablm_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_kind,
  input logic               out_last,
  input logic [4:0]         out_bars,
  input logic signed [10:0] out_level,
  input logic signed [15:0] out_max,
  input logic signed [15:0] out_min,
  input logic signed [23:0] out_avg
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_level))
    else $error("result word dropped or changed while stalled");

  a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind |-> out_last)
    else $error("summary word without last");

  a_report_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_kind |-> out_max == 16'sd0 && out_min == 16'sd0 && out_avg == 24'sd0)
    else $error("block report carries recording statistics");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_bars <= 5'd20 && (out_level[10] || out_level == 11'sd0))
    else $error("level or bars out of range");

  a_after_summary: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_kind |=> !out_valid)
    else $error("word after the summary");
endmodule

bind audio_block_level_meter_core ablm_chk u_ablm_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_kind  (out_ch.kind),
  .out_last  (out_ch.last),
  .out_bars  (out_ch.bars),
  .out_level (out_ch.level_tenth_db),
  .out_max   (out_ch.max_amplitude),
  .out_min   (out_ch.min_amplitude),
  .out_avg   (out_ch.average_q8)
);
